// ===== rtl/icfe_pkg.sv =====
// Shared types, constants and helper functions of the cell format encoder.
`timescale 1ns / 1ps

package icfe_pkg;

    localparam int CHAR_W      = 21;
    localparam int COLOUR_W    = 8;
    localparam int DIGIT_W     = 4;
    localparam int QUEUE_DEPTH = 4;

    // Fixed emission order of everything one cell can produce.
    localparam int NUM_SLOTS = 13;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    typedef enum logic [SLOT_W-1:0] {
        SLOT_BOLD      = 4'd0,
        SLOT_ITALIC    = 4'd1,
        SLOT_UNDERLINE = 4'd2,
        SLOT_RESET     = 4'd3,
        SLOT_COLOUR    = 4'd4,
        SLOT_COLOUR2   = 4'd5,
        SLOT_FG_TENS   = 4'd6,
        SLOT_FG_ONES   = 4'd7,
        SLOT_COMMA     = 4'd8,
        SLOT_BG_TENS   = 4'd9,
        SLOT_BG_ONES   = 4'd10,
        SLOT_GLYPH     = 4'd11,
        SLOT_NEWLINE   = 4'd12
    } t_slot;

    localparam logic [CHAR_W-1:0] CH_BOLD      = 21'h02;
    localparam logic [CHAR_W-1:0] CH_COLOUR    = 21'h03;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 21'h0A;
    localparam logic [CHAR_W-1:0] CH_RESET     = 21'h0F;
    localparam logic [CHAR_W-1:0] CH_ITALIC    = 21'h1D;
    localparam logic [CHAR_W-1:0] CH_UNDERLINE = 21'h1F;
    localparam logic [CHAR_W-1:0] CH_COMMA     = 21'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO      = 21'h30;
    localparam logic [CHAR_W-1:0] CH_NINE      = 21'h39;

    localparam logic signed [COLOUR_W-1:0] COLOUR_DEFAULT = -8'sd1;
    localparam logic signed [COLOUR_W-1:0] COLOUR_MAX     = 8'sd98;
    localparam logic signed [COLOUR_W-1:0] ROW_FG         = 8'sd15;
    localparam logic signed [COLOUR_W-1:0] ROW_BG         = COLOUR_DEFAULT;

    typedef struct packed {
        logic                       bold;
        logic                       italic;
        logic                       underline;
        logic signed [COLOUR_W-1:0] fg_colour;
        logic signed [COLOUR_W-1:0] bg_colour;
        logic [CHAR_W-1:0]          glyph;
        logic                       row_end;
    } t_cell;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
    } t_result;

    // Classified cell: which slots to emit plus the data they need.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [DIGIT_W-1:0]   fg_tens;
        logic [DIGIT_W-1:0]   fg_ones;
        logic [DIGIT_W-1:0]   bg_tens;
        logic [DIGIT_W-1:0]   bg_ones;
        logic [CHAR_W-1:0]    glyph;
    } t_cmd;

    typedef struct packed {
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } t_digits;

    function automatic logic signed [COLOUR_W-1:0] colour_sat(
        input logic signed [COLOUR_W-1:0] v
    );
        logic signed [COLOUR_W-1:0] r;
        r = v;
        if (v > COLOUR_MAX) begin
            r = COLOUR_MAX;
        end else if (v < COLOUR_DEFAULT) begin
            r = COLOUR_DEFAULT;
        end
        return r;
    endfunction

    // Splits 0..98 into decimal digits; v*205>>11 equals v/10 over this range.
    function automatic t_digits dec_split(input logic [6:0] v);
        logic [14:0] prod;
        t_digits     d;
        prod   = 15'(v) * 15'd205;
        d.tens = prod[14:11];
        d.ones = 4'(v - (7'(d.tens) * 7'd10));
        return d;
    endfunction

endpackage

// ===== rtl/icfe_front.sv =====
// Front end: holds the current formatting state and classifies each cell.
`timescale 1ns / 1ps

module icfe_front import icfe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cell i_cell,
    input  logic  i_full,
    output logic  o_push,
    output t_cmd  o_cmd
);

    logic                       r_bold, n_bold;
    logic                       r_italic, n_italic;
    logic                       r_underline, n_underline;
    logic signed [COLOUR_W-1:0] r_fg, n_fg;
    logic signed [COLOUR_W-1:0] r_bg, n_bg;

    logic signed [COLOUR_W-1:0] fg, bg;
    logic                       digit, fc, bc, fg_def, bg_def;
    logic                       f_reset, f_a, f_b, f_c, f_any;
    t_digits                    fg_d, bg_d;
    logic                       accept;

    assign accept = i_push && !i_full;
    assign o_push = accept;

    always_comb begin
        fg     = colour_sat(i_cell.fg_colour);
        bg     = colour_sat(i_cell.bg_colour);
        digit  = (i_cell.glyph >= CH_ZERO) && (i_cell.glyph <= CH_NINE);
        fc     = fg != r_fg;
        bc     = bg != r_bg;
        fg_def = fg == COLOUR_DEFAULT;
        bg_def = bg == COLOUR_DEFAULT;
        fg_d   = dec_split(fg[6:0]);
        bg_d   = dec_split(bg[6:0]);

        f_reset = bc && bg_def && fc && fg_def;
        f_a     = !bc && fc && !fg_def;
        f_b     = bc && bg_def && fc && !fg_def;
        f_c     = bc && !bg_def && !fg_def;
        f_any   = f_a || f_b || f_c;

        o_cmd.mask                 = '0;
        o_cmd.mask[SLOT_BOLD]      = i_cell.bold != r_bold;
        o_cmd.mask[SLOT_ITALIC]    = i_cell.italic != r_italic;
        o_cmd.mask[SLOT_UNDERLINE] = i_cell.underline != r_underline;
        o_cmd.mask[SLOT_RESET]     = f_reset;
        o_cmd.mask[SLOT_COLOUR]    = f_any;
        o_cmd.mask[SLOT_COLOUR2]   = f_b;
        // The number that closes the sequence is padded when a digit follows it.
        o_cmd.mask[SLOT_FG_TENS]   = f_any && ((fg_d.tens != '0) || ((f_a || f_b) && digit));
        o_cmd.mask[SLOT_FG_ONES]   = f_any;
        o_cmd.mask[SLOT_COMMA]     = f_c;
        o_cmd.mask[SLOT_BG_TENS]   = f_c && ((bg_d.tens != '0) || digit);
        o_cmd.mask[SLOT_BG_ONES]   = f_c;
        o_cmd.mask[SLOT_GLYPH]     = 1'b1;
        o_cmd.mask[SLOT_NEWLINE]   = i_cell.row_end;
        o_cmd.fg_tens              = fg_d.tens;
        o_cmd.fg_ones              = fg_d.ones;
        o_cmd.bg_tens              = bg_d.tens;
        o_cmd.bg_ones              = bg_d.ones;
        o_cmd.glyph                = i_cell.glyph;
    end

    always_comb begin
        n_bold      = r_bold;
        n_italic    = r_italic;
        n_underline = r_underline;
        n_fg        = r_fg;
        n_bg        = r_bg;
        if (accept) begin
            if (i_cell.row_end) begin
                n_bold      = 1'b0;
                n_italic    = 1'b0;
                n_underline = 1'b0;
                n_fg        = ROW_FG;
                n_bg        = ROW_BG;
            end else begin
                n_bold      = i_cell.bold;
                n_italic    = i_cell.italic;
                n_underline = i_cell.underline;
                if (fc || bc) begin
                    n_fg = fg;
                    n_bg = bg;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bold      <= 1'b0;
            r_italic    <= 1'b0;
            r_underline <= 1'b0;
            r_fg        <= ROW_FG;
            r_bg        <= ROW_BG;
        end else begin
            r_bold      <= n_bold;
            r_italic    <= n_italic;
            r_underline <= n_underline;
            r_fg        <= n_fg;
            r_bg        <= n_bg;
        end
    end

endmodule

// ===== rtl/icfe_queue.sv =====
// Short command queue between the front end and the character sequencer.
`timescale 1ns / 1ps

module icfe_queue import icfe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/icfe_back.sv =====
// Back end: expands queued commands into characters, one per cycle while i_pop keeps up.
`timescale 1ns / 1ps

module icfe_back import icfe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_empty,
    output logic    o_cmd_pop,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    t_cmd                 r_cmd, n_cmd;
    logic [NUM_SLOTS-1:0] r_mask, n_mask;
    t_result              r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    t_cmd                 src_cmd;
    logic [NUM_SLOTS-1:0] src_mask, rest;
    logic                 load, advance, emit;
    t_slot                sel;
    logic [CHAR_W-1:0]    ch;

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_comb begin
        // With nothing left of the current command, work straight from the queue head.
        load     = (r_mask == '0) && !i_cmd_empty;
        src_cmd  = load ? i_cmd : r_cmd;
        src_mask = load ? i_cmd.mask : r_mask;
        advance  = !r_out_valid || i_pop;
        emit     = advance && (src_mask != '0);

        sel = SLOT_NEWLINE;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (src_mask[i]) begin
                sel = t_slot'(SLOT_W'(i));
            end
        end
        rest = src_mask & ~(NUM_SLOTS'(1) << sel);

        case (sel)
            SLOT_BOLD:      ch = CH_BOLD;
            SLOT_ITALIC:    ch = CH_ITALIC;
            SLOT_UNDERLINE: ch = CH_UNDERLINE;
            SLOT_RESET:     ch = CH_RESET;
            SLOT_COLOUR:    ch = CH_COLOUR;
            SLOT_COLOUR2:   ch = CH_COLOUR;
            SLOT_FG_TENS:   ch = CH_ZERO + CHAR_W'(src_cmd.fg_tens);
            SLOT_FG_ONES:   ch = CH_ZERO + CHAR_W'(src_cmd.fg_ones);
            SLOT_COMMA:     ch = CH_COMMA;
            SLOT_BG_TENS:   ch = CH_ZERO + CHAR_W'(src_cmd.bg_tens);
            SLOT_BG_ONES:   ch = CH_ZERO + CHAR_W'(src_cmd.bg_ones);
            SLOT_GLYPH:     ch = src_cmd.glyph;
            SLOT_NEWLINE:   ch = CH_NEWLINE;
            default:        ch = '0;
        endcase

        o_cmd_pop   = load && emit;
        n_cmd       = o_cmd_pop ? i_cmd : r_cmd;
        n_mask      = emit ? rest : r_mask;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out.out_char = ch;
            n_out.last     = rest == '0;
            n_out_valid    = 1'b1;
        end else if (advance) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/irc_cell_format_encoder_top.sv =====
// Top level of the cell format encoder: front end, command queue and sequencer.
`timescale 1ns / 1ps

// Each request carries one text cell; the block turns it into the formatting
// codes that bring the current attributes and colours to the cell's, then the
// cell's character and a newline at the end of a row, marking the final
// character of the cell with last. A cell yields 1 to 11 characters (1 to 10
// without a newline, 2 to 11 with one), delivered by the single output register
// at one character per cycle while the consumer pops. Cells are accepted one
// per cycle into a 4-entry command queue while it is not full; full rises only
// when all four entries of that queue are occupied. The first character of a
// cell passes through the command queue and then the output register before it
// appears at the output.
module irc_cell_format_encoder_top import icfe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_cell   i_cell,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    logic q_push, q_full, q_pop, q_empty;
    t_cmd q_in, q_out;

    assign full = q_full;

    icfe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cell  (i_cell),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (q_in)
    );

    icfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    icfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_out),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

// ===== sim/tb_top.sv =====
// Testbench of the cell format encoder: directed and random cells, scoreboard check.
`timescale 1ns / 1ps

module tb_top import icfe_pkg::*;;

    localparam int CLK_HALF    = 2;
    localparam int RESET_LEN   = 5;
    localparam int RANDOM_CELLS = 135;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SHOW_MAX     = 10;

    // Predicts the character stream of each pushed cell and checks the popped
    // results against it in order.
    class cell_scoreboard;
        logic                       cur_bold;
        logic                       cur_italic;
        logic                       cur_underline;
        logic signed [COLOUR_W-1:0] cur_fg;
        logic signed [COLOUR_W-1:0] cur_bg;
        logic [CHAR_W-1:0]          cell_chars[$];
        t_result                    expected_chars[$];
        int                         errors;
        int                         shown;
        int                         checked;
        int                         cells;
        int                         rows;

        function new();
            errors  = 0;
            shown   = 0;
            checked = 0;
            cells   = 0;
            rows    = 0;
            row_start();
        endfunction

        function void row_start();
            cur_bold      = 1'b0;
            cur_italic    = 1'b0;
            cur_underline = 1'b0;
            cur_fg        = ROW_FG;
            cur_bg        = ROW_BG;
        endfunction

        function logic signed [COLOUR_W-1:0] clamp_colour(logic signed [COLOUR_W-1:0] raw);
            if (raw > 8'sd98) begin
                return 8'sd98;
            end
            if (raw < -8'sd1) begin
                return -8'sd1;
            end
            return raw;
        endfunction

        function void emit(logic [CHAR_W-1:0] c);
            cell_chars.push_back(c);
        endfunction

        function void emit_number(int v, bit pad);
            if (v >= 10) begin
                emit(CHAR_W'(CH_ZERO + v / 10));
            end else if (pad) begin
                emit(CH_ZERO);
            end
            emit(CHAR_W'(CH_ZERO + v % 10));
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void note_cell(t_cell c);
            logic signed [COLOUR_W-1:0] fg;
            logic signed [COLOUR_W-1:0] bg;
            bit                         digit;
            bit                         fg_diff;
            bit                         bg_diff;
            t_result                    r;
            fg = clamp_colour(c.fg_colour);
            bg = clamp_colour(c.bg_colour);
            digit = (c.glyph >= CH_ZERO) && (c.glyph <= CH_NINE);
            cell_chars.delete();
            cells++;

            if (c.bold != cur_bold) begin
                emit(CH_BOLD);
                cur_bold = c.bold;
            end
            if (c.italic != cur_italic) begin
                emit(CH_ITALIC);
                cur_italic = c.italic;
            end
            if (c.underline != cur_underline) begin
                emit(CH_UNDERLINE);
                cur_underline = c.underline;
            end

            fg_diff = (fg != cur_fg);
            bg_diff = (bg != cur_bg);
            if (fg_diff || bg_diff) begin
                if (bg_diff && bg == COLOUR_DEFAULT && fg_diff && fg == COLOUR_DEFAULT) begin
                    emit(CH_RESET);
                end else if (!bg_diff && fg_diff && fg != COLOUR_DEFAULT) begin
                    emit(CH_COLOUR);
                    emit_number(fg, digit);
                end else if (bg_diff && bg == COLOUR_DEFAULT && fg_diff) begin
                    emit(CH_COLOUR);
                    emit(CH_COLOUR);
                    emit_number(fg, digit);
                end else if (bg_diff && bg != COLOUR_DEFAULT && fg != COLOUR_DEFAULT) begin
                    // Only the number that closes the sequence is padded.
                    emit(CH_COLOUR);
                    emit_number(fg, 1'b0);
                    emit(CH_COMMA);
                    emit_number(bg, digit);
                end
                cur_fg = fg;
                cur_bg = bg;
            end

            emit(c.glyph);
            if (c.row_end) begin
                emit(CH_NEWLINE);
                rows++;
                row_start();
            end

            foreach (cell_chars[i]) begin
                r.out_char = cell_chars[i];
                r.last     = (i == cell_chars.size() - 1);
                expected_chars.push_back(r);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_chars.size() == 0) begin
                errors++;
                if (shown < SHOW_MAX) begin
                    shown++;
                    $display("unexpected result: out_char=%h last=%b", got.out_char, got.last);
                end
                return;
            end
            want = expected_chars.pop_front();
            checked++;
            if (got.out_char !== want.out_char || got.last !== want.last) begin
                errors++;
                if (shown < SHOW_MAX) begin
                    shown++;
                    $display("mismatch at result %0d: out_char exp %h got %h, last exp %b got %b",
                             checked, want.out_char, got.out_char, want.last, got.last);
                end
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    push;
    logic    full;
    t_cell   i_cell;
    logic    empty;
    logic    pop;
    t_result o_result;

    cell_scoreboard sb;
    bit             steady;
    int             cycle_count;
    t_cell          directed[$];

    irc_cell_format_encoder_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_cell   (i_cell),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_HALF) i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one, none during steady stretches.
    function automatic int idle_len();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_cell mk(bit b, bit it, bit ul, int fg, int bg, int g, bit re);
        t_cell c;
        c.bold      = b;
        c.italic    = it;
        c.underline = ul;
        c.fg_colour = COLOUR_W'(fg);
        c.bg_colour = COLOUR_W'(bg);
        c.glyph     = CHAR_W'(g);
        c.row_end   = re;
        return c;
    endfunction

    function automatic logic signed [COLOUR_W-1:0] rand_colour();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            return COLOUR_DEFAULT;
        end else if (r < 60) begin
            return COLOUR_W'($urandom_range(0, 15));
        end else if (r < 90) begin
            return COLOUR_W'($urandom_range(0, 98));
        end
        return COLOUR_W'($urandom);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_glyph();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            return CHAR_W'($urandom_range(CH_ZERO, CH_NINE));
        end else if (r < 70) begin
            return CHAR_W'($urandom_range(8'h20, 8'h7E));
        end else if (r < 90) begin
            return CHAR_W'($urandom_range(0, 21'h10FFFF));
        end
        return CHAR_W'($urandom);
    endfunction

    // Neighbours mostly share attributes and background; foreground mostly changes.
    function automatic t_cell rand_cell(t_cell prev, bit re);
        t_cell c;
        c = prev;
        if ($urandom_range(0, 3) == 0) c.bold = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) c.italic = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) c.underline = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) < 3) c.fg_colour = rand_colour();
        if ($urandom_range(0, 4) < 2) c.bg_colour = rand_colour();
        c.glyph   = rand_glyph();
        c.row_end = re;
        return c;
    endfunction

    task automatic send_cell(input t_cell c);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_cell <= c;
        do @(posedge i_clk); while (full);
        sb.note_cell(c);
    endtask

    task automatic send_random(input int count);
        t_cell prev;
        int    row_left;
        bit    re;
        prev     = mk(0, 0, 0, ROW_FG, ROW_BG, 8'h41, 0);
        row_left = 0;
        for (int n = 0; n < count; n++) begin
            steady = (n >= 40 && n < 70);
            if (row_left == 0) begin
                row_left = $urandom_range(1, 12);
            end
            re = (row_left == 1) || ($urandom_range(0, 19) == 0);
            row_left--;
            prev = rand_cell(prev, re);
            send_cell(prev);
        end
        steady = 1'b0;
    endtask

    initial begin
        pop <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            int stall;
            stall = idle_len();
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_result(o_result);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILURE");
        $finish;
    end

    initial begin
        sb      = new();
        steady  = 1'b0;
        i_rst_n <= 1'b0;
        push    <= 1'b0;
        i_cell  <= '0;
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!i_rst_n) @(posedge i_clk);

        directed.push_back(mk(0, 0, 0, 15, -1, 8'h41, 0));
        directed.push_back(mk(1, 0, 0, 15, -1, 8'h42, 0));
        directed.push_back(mk(0, 1, 1, 15, -1, 8'h43, 0));
        directed.push_back(mk(0, 1, 1, 4, -1, 8'h37, 0));
        directed.push_back(mk(0, 1, 1, 12, -1, 8'h33, 0));
        directed.push_back(mk(0, 1, 1, 9, -1, 8'h78, 0));
        directed.push_back(mk(0, 1, 1, 10, -1, 8'h35, 0));
        directed.push_back(mk(0, 0, 0, 5, 2, 8'h30, 0));
        // Background back to default with the same foreground emits no colour code.
        directed.push_back(mk(0, 0, 0, 5, -1, 8'h61, 0));
        // A background with a default foreground emits no colour code either.
        directed.push_back(mk(0, 0, 0, -1, 3, 8'h62, 0));
        directed.push_back(mk(0, 0, 0, 7, 9, 8'h63, 0));
        directed.push_back(mk(0, 0, 0, -1, -1, 8'h64, 0));
        directed.push_back(mk(0, 0, 0, 20, -1, 8'h65, 0));
        directed.push_back(mk(0, 0, 0, -1, -1, 8'h66, 0));
        directed.push_back(mk(0, 0, 0, 33, 44, 8'h67, 0));
        directed.push_back(mk(0, 0, 0, 98, -1, 8'h38, 0));
        // Out-of-range colours saturate before they are compared.
        directed.push_back(mk(0, 0, 0, 127, -128, 8'h68, 0));
        directed.push_back(mk(0, 0, 0, -2, 99, 8'h69, 0));
        directed.push_back(mk(0, 0, 0, 0, 0, 8'h2F, 0));
        directed.push_back(mk(0, 0, 0, 1, 0, 8'h3A, 0));
        directed.push_back(mk(0, 0, 0, 1, 0, 21'h1FFFFF, 1));
        // Longest possible output of one cell.
        directed.push_back(mk(1, 1, 1, 97, 88, 8'h39, 1));
        directed.push_back(mk(0, 0, 0, 15, -1, 21'h10FFFF, 0));
        directed.push_back(mk(0, 0, 0, 15, -1, 0, 1));
        directed.push_back(mk(0, 0, 0, 3, 5, 8'h34, 1));

        foreach (directed[i]) begin
            send_cell(directed[i]);
        end
        send_random(RANDOM_CELLS);
        push <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d cells over %0d rows and checked %0d characters.",
                 sb.cells, sb.rows, sb.checked);
        $display("Errors: %0d, characters still expected: %0d.", sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/icfe_pkg.sv
rtl/icfe_front.sv
rtl/icfe_queue.sv
rtl/icfe_back.sv
rtl/irc_cell_format_encoder_top.sv
sim/tb_top.sv
